[hw/rtl/aavr_pkg.sv]
package aavr_pkg;

  // Q30 Taylor coefficients of the quarter-wave sine
  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172271;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  // normalize pipeline: sqrt steps then divide steps
  localparam int SQ_STEPS = 30;   // n2<<28 < 2^60, so the root has 30 bits
  localparam int DIV_STEPS = 16;  // quotient bits (|u| <= 16384)

  // stage counts of the datapath
  localparam int SINE_LAT = 6;
  localparam int NORM_LAT = SQ_STEPS + DIV_STEPS + 2;
  localparam int MV_LAT = 4;
  localparam int PIPE_LAT = NORM_LAT + MV_LAT;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [15:0] ang;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic zero;
  } out_word_t;

  // saturate a rounded result to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) return 16'sh7fff;
    if (v < -22'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

[hw/rtl/aavr_if.sv]
interface aavr_in_if (input logic clk);
  logic valid;
  logic ready;
  aavr_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aavr_out_if (input logic clk);
  logic valid;
  logic ready;
  aavr_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/aavr_sine.sv]
// quarter-wave sine, one multiply per stage, advances when en is high
module aavr_sine (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] f,
  output logic [14:0] s
);
  // stage registers: f and g travel, p updated per Horner step
  logic [16:0] f_r [0:4];
  logic [31:0] g_r [0:3];
  logic [31:0] p_r [0:4];
  logic [63:0] pg [0:3];
  logic [48:0] pf;
  logic [33:0] fs;
  logic [14:0] s_r;

  assign fs = 34'(f) * 34'(f);

  always_comb begin
    for (int k = 0; k < 4; k++) pg[k] = 64'(p_r[k]) * 64'(g_r[k]);
  end
  assign pf = 49'(p_r[4]) * 49'(f_r[4]);

  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0] <= f;
      g_r[0] <= fs[33:2];
      p_r[0] <= aavr_pkg::C9;
      for (int k = 1; k < 5; k++) f_r[k] <= f_r[k-1];
      for (int k = 1; k < 4; k++) g_r[k] <= g_r[k-1];
      p_r[1] <= aavr_pkg::C7 - pg[0][61:30];
      p_r[2] <= aavr_pkg::C5 - pg[1][61:30];
      p_r[3] <= aavr_pkg::C3 - pg[2][61:30];
      p_r[4] <= aavr_pkg::C1 - pg[3][61:30];
      if (((pf + 49'(33'h80000000)) >> 32) > 49'(aavr_pkg::ONE_Q14)) s_r <= 15'd16384;
      else s_r <= 15'(((pf + 49'(33'h80000000)) >> 32));
    end
  end
  assign s = s_r;
endmodule

[hw/rtl/aavr_norm.sv]
// axis normalize: restoring isqrt then three restoring dividers, one bit per stage
module aavr_norm (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  output logic signed [15:0] ux,
  output logic signed [15:0] uy,
  output logic signed [15:0] uz
);
  // n2 < 2^32, n2<<28 < 2^60: root < 2^30, 30 steps
  logic [32:0] n2;
  assign n2 = 33'(32'(ax) * 32'(ax)) + 33'(32'(ay) * 32'(ay)) + 33'(32'(az) * 32'(az));

  logic [61:0] rem_r [0:aavr_pkg::SQ_STEPS];
  logic [29:0] root_r [0:aavr_pkg::SQ_STEPS];
  logic signed [15:0] a_r [0:aavr_pkg::SQ_STEPS][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, n2[32:0], 28'd0};
      root_r[0] <= '0;
      a_r[0][0] <= ax; a_r[0][1] <= ay; a_r[0][2] <= az;
      for (int k = 0; k < aavr_pkg::SQ_STEPS; k++) begin
        logic [61:0] t;
        t = {root_r[k], 2'b01} << (2 * (aavr_pkg::SQ_STEPS - 1 - k));
        if (rem_r[k] >= t) begin
          rem_r[k+1] <= rem_r[k] - t;
          root_r[k+1] <= {root_r[k][28:0], 1'b1};
        end else begin
          rem_r[k+1] <= rem_r[k];
          root_r[k+1] <= {root_r[k][28:0], 1'b0};
        end
        a_r[k+1] <= a_r[k];
      end
    end
  end

  // divide (|a|*2^28 + len/2) / len, quotient < 2^15 fits 16 bits
  logic [29:0] len_r [0:aavr_pkg::DIV_STEPS];
  logic [45:0] dn_r [0:aavr_pkg::DIV_STEPS][0:2];
  logic [15:0] q_r [0:aavr_pkg::DIV_STEPS][0:2];
  logic sg_r [0:aavr_pkg::DIV_STEPS][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= root_r[aavr_pkg::SQ_STEPS];
      for (int i = 0; i < 3; i++) begin
        logic [15:0] m;
        m = a_r[aavr_pkg::SQ_STEPS][i][15] ? 16'(-a_r[aavr_pkg::SQ_STEPS][i])
                                           : a_r[aavr_pkg::SQ_STEPS][i];
        dn_r[0][i] <= ({30'd0, m} << 28) + 46'(root_r[aavr_pkg::SQ_STEPS] >> 1);
        q_r[0][i] <= '0;
        sg_r[0][i] <= a_r[aavr_pkg::SQ_STEPS][i][15];
      end
      for (int k = 0; k < aavr_pkg::DIV_STEPS; k++) begin
        len_r[k+1] <= len_r[k];
        for (int i = 0; i < 3; i++) begin
          logic [45:0] d;
          d = 46'(len_r[k]) << (aavr_pkg::DIV_STEPS - 1 - k);
          sg_r[k+1][i] <= sg_r[k][i];
          if (dn_r[k][i] >= d) begin
            dn_r[k+1][i] <= dn_r[k][i] - d;
            q_r[k+1][i] <= {q_r[k][i][14:0], 1'b1};
          end else begin
            dn_r[k+1][i] <= dn_r[k][i];
            q_r[k+1][i] <= {q_r[k][i][14:0], 1'b0};
          end
        end
      end
    end
  end

  assign ux = sg_r[aavr_pkg::DIV_STEPS][0] ? -$signed(q_r[aavr_pkg::DIV_STEPS][0])
                                           : $signed(q_r[aavr_pkg::DIV_STEPS][0]);
  assign uy = sg_r[aavr_pkg::DIV_STEPS][1] ? -$signed(q_r[aavr_pkg::DIV_STEPS][1])
                                           : $signed(q_r[aavr_pkg::DIV_STEPS][1]);
  assign uz = sg_r[aavr_pkg::DIV_STEPS][2] ? -$signed(q_r[aavr_pkg::DIV_STEPS][2])
                                           : $signed(q_r[aavr_pkg::DIV_STEPS][2]);
endmodule

[hw/rtl/aavr_matvec.sv]
// rodrigues matrix then transposed product, rounding and saturation
module aavr_matvec (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] u [0:2],
  input  logic signed [15:0] sn,
  input  logic signed [15:0] cs,
  input  logic signed [15:0] v [0:2],
  output logic signed [15:0] r [0:2]
);
  // stage a: oc*u_i, u_k*sn
  logic signed [17:0] oc;
  assign oc = 18'sd16384 - 18'(cs);
  logic signed [33:0] ocu_r [0:2];
  logic signed [31:0] su_r [0:2];
  logic signed [15:0] ua_r [0:2], va_r [0:2], csa_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ocu_r[i] <= 34'(oc) * 34'(u[i]);
        su_r[i] <= 32'(u[i]) * 32'(sn);
        ua_r[i] <= u[i];
        va_r[i] <= v[i];
      end
      csa_r <= cs;
    end
  end

  // stage b: matrix entries in Q42, kept exact
  logic signed [46:0] m_r [0:2][0:2];
  logic signed [15:0] vb_r [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          logic signed [49:0] p;
          p = 50'(ocu_r[i]) * 50'(ua_r[j]);
          m_r[i][j] <= 47'(p);
        end
      vb_r <= va_r;
    end
  end
  // cosine and sine terms in Q42
  logic signed [46:0] mm [0:2][0:2];
  logic signed [46:0] cq_b_r, sx_b_r, sy_b_r, sz_b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      cq_b_r <= 47'(csa_r) <<< 28;
      sx_b_r <= 47'(su_r[0]) <<< 14;
      sy_b_r <= 47'(su_r[1]) <<< 14;
      sz_b_r <= 47'(su_r[2]) <<< 14;
    end
  end
  always_comb begin
    mm = m_r;
    mm[0][0] = m_r[0][0] + cq_b_r; mm[1][1] = m_r[1][1] + cq_b_r;
    mm[2][2] = m_r[2][2] + cq_b_r;
    mm[0][1] = m_r[0][1] - sz_b_r; mm[1][0] = m_r[1][0] + sz_b_r;
    mm[0][2] = m_r[0][2] + sy_b_r; mm[2][0] = m_r[2][0] - sy_b_r;
    mm[1][2] = m_r[1][2] - sx_b_r; mm[2][1] = m_r[2][1] + sx_b_r;
  end

  // stage c: products, pr_r[i][j] = R[j][i] * v_j
  logic signed [62:0] pr_r [0:2][0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pr_r[i][j] <= 63'(mm[j][i]) * 63'(vb_r[j]);
    end
  end

  // stage d: sum, round half away from zero by 2^42, saturate
  logic signed [15:0] r_r [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [64:0] acc;
        logic [64:0] mg, q;
        acc = 65'(pr_r[i][0]) + 65'(pr_r[i][1]) + 65'(pr_r[i][2]);
        mg = acc[64] ? 65'(-acc) : 65'(acc);
        q = (mg + (65'd1 << 41)) >> 42;
        r_r[i] <= aavr_pkg::sat16(acc[64] ? -$signed(22'(q)) : $signed(22'(q)));
      end
    end
  end
  assign r = r_r;
endmodule

[hw/rtl/axis_angle_vector_rotation_top.sv]
// throughput: one word per cycle unless the output stalls; every stage
//   is a register, the widest being a 32x32 multiply in the sine stages
//   and one subtract in sqrt
// a stalled output freezes the whole pipeline in place; nothing is lost
// reset: synchronous active-low rst_n clears all valid bits
module axis_angle_vector_rotation_top (
  input  logic clk,
  input  logic rst_n,
  aavr_in_if.sink    in_ch,
  aavr_out_if.source out_ch
);
  logic en;
  logic [aavr_pkg::PIPE_LAT-1:0] vld_r;
  assign en = !vld_r[aavr_pkg::PIPE_LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[aavr_pkg::PIPE_LAT-2:0], in_ch.valid};
  end

  aavr_pkg::in_word_t d;
  assign d = in_ch.data;

  logic signed [15:0] u [0:2];
  aavr_norm u_norm (.clk, .en, .ax(d.ax), .ay(d.ay), .az(d.az),
                    .ux(u[0]), .uy(u[1]), .uz(u[2]));

  // sine inputs delayed so results line up with normalize output
  logic [13:0] ang_dl_r [0:aavr_pkg::NORM_LAT-aavr_pkg::SINE_LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      ang_dl_r[0] <= d.ang[13:0];
      for (int k = 1; k < aavr_pkg::NORM_LAT - aavr_pkg::SINE_LAT; k++)
        ang_dl_r[k] <= ang_dl_r[k-1];
    end
  end
  logic [16:0] fs, fc;
  assign fs = {1'b0, ang_dl_r[aavr_pkg::NORM_LAT-aavr_pkg::SINE_LAT-1], 2'b00};
  assign fc = 17'h10000 - fs;
  logic [14:0] s0, c0;
  aavr_sine u_ss (.clk, .en, .f(fs), .s(s0));
  aavr_sine u_sc (.clk, .en, .f(fc), .s(c0));
  logic [1:0] q_dl_r [0:aavr_pkg::NORM_LAT-1];
  logic signed [15:0] vd_r [0:aavr_pkg::NORM_LAT-1][0:2];
  logic z_dl_r [0:aavr_pkg::PIPE_LAT-1];
  logic signed [15:0] vo_r [0:aavr_pkg::MV_LAT-1][0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      q_dl_r[0] <= d.ang[15:14];
      vd_r[0][0] <= d.vx; vd_r[0][1] <= d.vy; vd_r[0][2] <= d.vz;
      z_dl_r[0] <= (d.ax == 16'sd0) && (d.ay == 16'sd0) && (d.az == 16'sd0);
      for (int k = 1; k < aavr_pkg::NORM_LAT; k++) begin
        q_dl_r[k] <= q_dl_r[k-1];
        vd_r[k] <= vd_r[k-1];
      end
      for (int k = 1; k < aavr_pkg::PIPE_LAT; k++) z_dl_r[k] <= z_dl_r[k-1];
      vo_r[0] <= vd_r[aavr_pkg::NORM_LAT-1];
      for (int k = 1; k < aavr_pkg::MV_LAT; k++) vo_r[k] <= vo_r[k-1];
    end
  end

  // quadrant mapping
  logic signed [15:0] sn, cs;
  always_comb begin
    case (q_dl_r[aavr_pkg::NORM_LAT-1])
      2'd0: begin sn = 16'(s0);  cs = 16'(c0);  end
      2'd1: begin sn = 16'(c0);  cs = -16'(s0); end
      2'd2: begin sn = -16'(s0); cs = -16'(c0); end
      default: begin sn = -16'(c0); cs = 16'(s0); end
    endcase
  end

  logic signed [15:0] r [0:2];
  aavr_matvec u_mv (.clk, .en, .u, .sn, .cs, .v(vd_r[aavr_pkg::NORM_LAT-1]), .r);

  // result word: vector passed through on a zero axis
  logic z_out;
  assign z_out = z_dl_r[aavr_pkg::PIPE_LAT-1];
  assign out_ch.valid = vld_r[aavr_pkg::PIPE_LAT-1];
  assign out_ch.data = '{rx: (z_out ? vo_r[aavr_pkg::MV_LAT-1][0] : r[0]),
                         ry: (z_out ? vo_r[aavr_pkg::MV_LAT-1][1] : r[1]),
                         rz: (z_out ? vo_r[aavr_pkg::MV_LAT-1][2] : r[2]),
                         zero: z_out};
endmodule

[tb/axis_angle_vector_rotation_top_test.sv]
`timescale 1ns / 100ps

module axis_angle_vector_rotation_top_test;

  logic clk;
  logic rst_n;

  aavr_in_if  in_ch  (clk);
  aavr_out_if out_ch (clk);

  axis_angle_vector_rotation_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C3 = 64'd693598668;
  localparam longint unsigned SIN_C5 = 64'd85569306;
  localparam longint unsigned SIN_C7 = 64'd5026995;
  localparam longint unsigned SIN_C9 = 64'd172271;
  localparam longint UNIT_Q14 = 16384;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;

  aavr_pkg::in_word_t  pending_words[$];
  aavr_pkg::out_word_t rotated_words[$];
  int mismatches;
  int words_sent;
  int words_checked;
  int zero_axis_seen;
  int tx_gap;
  int rx_gap;
  int hold_count;
  bit hold_done;

  // floor integer square root
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // divide, rounding half away from zero
  function automatic longint div_half_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint shift_half_away(longint v, int n);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag + (longint'(1) <<< (n - 1))) >>> n;
    return (v < 0) ? -q : q;
  endfunction

  // quarter-wave sine by horner on f squared, q16 in, q14 out
  function automatic longint quarter_wave(longint unsigned f);
    longint unsigned g;
    longint unsigned p;
    longint unsigned s;
    g = (f * f) >> 2;
    p = SIN_C9;
    p = SIN_C7 - ((p * g) >> 30);
    p = SIN_C5 - ((p * g) >> 30);
    p = SIN_C3 - ((p * g) >> 30);
    p = SIN_C1 - ((p * g) >> 30);
    s = (p * f + (64'd1 << 31)) >> 32;
    if (s > 64'd16384) s = 64'd16384;
    return longint'(s);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // rotate by the transpose of the rodrigues matrix
  function automatic aavr_pkg::out_word_t rotate_word(aavr_pkg::in_word_t w);
    aavr_pkg::out_word_t r;
    longint a[3];
    longint v[3];
    longint u[3];
    longint m[3][3];
    longint unsigned n2;
    longint unsigned len;
    longint unsigned f;
    longint s0, c0, sn, cs, oc, cq, sx, sy, sz, acc;
    logic [1:0] quad;
    logic signed [15:0] res[3];
    a[0] = w.ax; a[1] = w.ay; a[2] = w.az;
    v[0] = w.vx; v[1] = w.vy; v[2] = w.vz;
    if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
      r.rx = w.vx; r.ry = w.vy; r.rz = w.vz; r.zero = 1'b1;
      return r;
    end
    n2 = longint'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    len = int_sqrt(n2 << 28);
    for (int i = 0; i < 3; i++) u[i] = div_half_away(a[i] <<< 28, longint'(len));
    quad = w.ang[15:14];
    f = longint'(w.ang[13:0]) << 2;
    s0 = quarter_wave(f);
    c0 = quarter_wave(64'd65536 - f);
    case (quad)
      2'd0: begin sn = s0;  cs = c0;  end
      2'd1: begin sn = c0;  cs = -s0; end
      2'd2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
    oc = UNIT_Q14 - cs;
    cq = cs <<< 28;
    sx = u[0] * sn * UNIT_Q14;
    sy = u[1] * sn * UNIT_Q14;
    sz = u[2] * sn * UNIT_Q14;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = oc * u[i] * u[j];
    m[0][0] += cq; m[1][1] += cq; m[2][2] += cq;
    m[0][1] -= sz; m[1][0] += sz;
    m[0][2] += sy; m[2][0] -= sy;
    m[1][2] -= sx; m[2][1] += sx;
    for (int i = 0; i < 3; i++) begin
      acc = m[0][i] * v[0] + m[1][i] * v[1] + m[2][i] * v[2];
      res[i] = clamp16(shift_half_away(acc, 42));
    end
    r.rx = res[0]; r.ry = res[1]; r.rz = res[2]; r.zero = 1'b0;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic aavr_pkg::in_word_t make_word(logic [15:0] ax, logic [15:0] ay,
                                                   logic [15:0] az, logic [15:0] ang,
                                                   logic [15:0] vx, logic [15:0] vy,
                                                   logic [15:0] vz);
    aavr_pkg::in_word_t w;
    w.ax = ax; w.ay = ay; w.az = az; w.ang = ang;
    w.vx = vx; w.vy = vy; w.vz = vz;
    return w;
  endfunction

  // random word: full-range fields, with small axes, zero axes, z-only axes and quadrant angles mixed in
  function automatic aavr_pkg::in_word_t random_word();
    aavr_pkg::in_word_t w;
    int r;
    w = make_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      w.ax = '0; w.ay = '0; w.az = '0;
    end else if (r < 20) begin
      w.ax = 16'($urandom_range(0, 6)) - 16'd3;
      w.ay = 16'($urandom_range(0, 6)) - 16'd3;
      w.az = 16'($urandom_range(0, 6)) - 16'd3;
    end else if (r < 28) begin
      w.ax = 16'sd0; w.ay = 16'sd0;
    end
    if ($urandom_range(0, 9) == 0)
      w.ang = {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
    return w;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      tx_gap <= 0;
      words_sent <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rotated_words.push_back(rotate_word(in_ch.data));
        words_sent <= words_sent + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_ch.data  <= pending_words.pop_front();
          in_ch.valid <= 1'b1;
          tx_gap <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result checker and ready
  always @(posedge clk) begin
    aavr_pkg::out_word_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap <= 0;
      mismatches <= 0;
      words_checked <= 0;
      zero_axis_seen <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rotated_words.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word %h", out_ch.data);
        end else begin
          exp_w = rotated_words.pop_front();
          words_checked <= words_checked + 1;
          if (out_ch.data.zero) zero_axis_seen <= zero_axis_seen + 1;
          if (out_ch.data.rx !== exp_w.rx || out_ch.data.ry !== exp_w.ry ||
              out_ch.data.rz !== exp_w.rz || out_ch.data.zero !== exp_w.zero) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp x %0d y %0d z %0d zero %b, got x %0d y %0d z %0d zero %b",
                       exp_w.rx, exp_w.ry, exp_w.rz, exp_w.zero,
                       out_ch.data.rx, out_ch.data.ry, out_ch.data.rz, out_ch.data.zero);
          end
        end
      end
      if (hold_count > 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rx_gap <= pick_gap();
      end
    end
  end

  // one long receiver hold-off so the pipeline backs up into the input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_count <= 0;
      hold_done <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
    end else if (!hold_done && words_sent >= 300) begin
      hold_count <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // stimulus and end of run
  initial begin
    rst_n = 1'b0;

    // directed words: zero axis, axis and vector extremes, quadrant angles, tiny axis
    pending_words.push_back(make_word(16'h0000, 16'h0000, 16'h0000, 16'h1234,
                                      16'h7fff, 16'h8000, 16'h0001));
    pending_words.push_back(make_word(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                      16'h8000, 16'h7fff, 16'h0000));
    pending_words.push_back(make_word(16'h4000, 16'h0000, 16'h0000, 16'h0000,
                                      16'h4000, 16'h4000, 16'h4000));
    pending_words.push_back(make_word(16'h0000, 16'h0000, 16'h4000, 16'h4000,
                                      16'h4000, 16'h0000, 16'h0000));
    pending_words.push_back(make_word(16'h0000, 16'h4000, 16'h0000, 16'h8000,
                                      16'h4000, 16'h2000, 16'hc000));
    pending_words.push_back(make_word(16'h4000, 16'h4000, 16'h4000, 16'hc000,
                                      16'h7fff, 16'h7fff, 16'h7fff));
    pending_words.push_back(make_word(16'h0001, 16'h0000, 16'h0000, 16'hffff,
                                      16'h8000, 16'h8000, 16'h8000));
    pending_words.push_back(make_word(16'h0000, 16'h0000, 16'hffff, 16'h3fff,
                                      16'h7fff, 16'h8000, 16'h7fff));
    pending_words.push_back(make_word(16'h8000, 16'h8000, 16'h8000, 16'h2000,
                                      16'h7fff, 16'h8000, 16'h0000));
    pending_words.push_back(make_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h6000,
                                      16'h7fff, 16'h7fff, 16'h8000));
    pending_words.push_back(make_word(16'h7fff, 16'h8000, 16'h0001, 16'h4001,
                                      16'h8000, 16'h7fff, 16'h7fff));
    pending_words.push_back(make_word(16'h0001, 16'h0001, 16'h0001, 16'h8001,
                                      16'h1111, 16'heeee, 16'h5555));
    pending_words.push_back(make_word(16'hffff, 16'h0002, 16'h0000, 16'hbfff,
                                      16'haaaa, 16'h5555, 16'haaaa));
    pending_words.push_back(make_word(16'h0000, 16'h7fff, 16'h0000, 16'h0001,
                                      16'h0000, 16'h0000, 16'h0000));
    pending_words.push_back(make_word(16'h3000, 16'hd000, 16'h1000, 16'ha000,
                                      16'h7fff, 16'h7fff, 16'h7fff));
    for (int i = 0; i < 1650; i++) pending_words.push_back(random_word());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0 && !in_ch.valid && rotated_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words, checked %0d results, %0d with a zero axis",
             words_sent, words_checked, zero_axis_seen);
    $display("covered axis and vector extremes, all quadrants, long output back-pressure");
    if (mismatches == 0 && rotated_words.size() == 0) begin
      $display("axis_angle_vector_rotation_top_test: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("axis_angle_vector_rotation_top_test: FAIL");
    end
    $finish;
  end

  // timeout
  initial begin
    #8000000;
    $display("timeout");
    $display("axis_angle_vector_rotation_top_test: FAIL");
    $finish;
  end

endmodule
